// ===== rtl/core/b2pcr_pkg.sv =====
// Shared constants, state encoding and control structs for the packet credit return block.
`default_nettype none
package b2pcr_pkg;

    localparam int QUEUE_DEPTH      = 16;
    localparam int MAX_PACKET_BYTES = 2048;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SIZE_W = $clog2(MAX_PACKET_BYTES + 1);

    localparam int AMOUNT_W  = 16;
    localparam int CREDITS_W = 5;
    localparam int HELD_W    = 5;
    localparam int HEAD_W    = 12;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_CONSUME = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;     // take the accepted item into the datapath
        logic step;     // one consumption walk step
        logic capture;  // move the result into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic left_zero;  // no consumed bytes remain to be applied
    } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/b2pcr_ctrl.sv =====
// Controller state machine: sequences accept, consumption walk and result hand-off.
`default_nettype none
module b2pcr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output b2pcr_pkg::dp_cmd_t        cmd,
    input  wire b2pcr_pkg::dp_status_t status
);
    import b2pcr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.left_zero)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_WALK:
            begin
                cmd.step = !status.left_zero;
            end
            ST_DONE:
            begin
                cmd.capture = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.capture)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule
`default_nettype wire

// ===== rtl/core/b2pcr_dp.sv =====
// Datapath: size FIFO, pointers, occupancy, consumption walk and output register.
`default_nettype none
module b2pcr_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire b2pcr_pkg::dp_cmd_t                   cmd,
    output b2pcr_pkg::dp_status_t                     status,
    input  wire logic                                 func,
    input  wire logic [b2pcr_pkg::AMOUNT_W-1:0]       amount,
    output logic [b2pcr_pkg::OUT_DATA_W-1:0]          out_data
);
    import b2pcr_pkg::*;

    logic [SIZE_W-1:0]   size_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [AMOUNT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0]    credits_reg, credits_next;
    logic                dropped_reg, dropped_next;
    logic                over_reg, over_next;
    logic [OUT_DATA_W-1:0] out_reg;
    logic [SIZE_W-1:0]   head_rd_reg;

    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    logic [SIZE_W-1:0]   wr_data;
    logic [SIZE_W-1:0]   head_bytes;
    logic [SIZE_W-1:0]   head_shown;
    logic [SIZE_W-1:0]   sat_len;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign head_bytes = head_rd_reg;
    assign sat_len = (amount > AMOUNT_W'(MAX_PACKET_BYTES)) ?
                     SIZE_W'(MAX_PACKET_BYTES) : SIZE_W'(amount);
    assign head_shown = (occ_reg == '0) ? '0 : head_bytes;
    assign status.left_zero = (left_reg == '0);

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        occ_next     = occ_reg;
        left_next    = left_reg;
        credits_next = credits_reg;
        dropped_next = dropped_reg;
        over_next    = over_reg;
        wr_en        = 1'b0;
        wr_addr      = tail_reg;
        wr_data      = sat_len;
        if (cmd.load)
        begin
            credits_next = '0;
            dropped_next = 1'b0;
            over_next    = 1'b0;
            left_next    = '0;
            if (func == FUNC_CONSUME)
            begin
                left_next = amount;
            end
            else if (amount == '0)
            begin
                credits_next = CNT_W'(1);
            end
            else if (occ_reg == CNT_W'(QUEUE_DEPTH))
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                wr_en     = 1'b1;
                tail_next = next_slot(tail_reg);
                occ_next  = occ_reg + CNT_W'(1);
            end
        end
        else if (cmd.step)
        begin
            if (occ_reg == '0)
            begin
                // Consumed bytes beyond everything queued are discarded.
                over_next = 1'b1;
                left_next = '0;
            end
            else if (left_reg >= AMOUNT_W'(head_bytes))
            begin
                left_next    = left_reg - AMOUNT_W'(head_bytes);
                head_next    = next_slot(head_reg);
                occ_next     = occ_reg - CNT_W'(1);
                credits_next = credits_reg + CNT_W'(1);
            end
            else
            begin
                wr_en     = 1'b1;
                wr_addr   = head_reg;
                wr_data   = head_bytes - SIZE_W'(left_reg);
                left_next = '0;
            end
        end
    end

    // The head read register follows the next head address, so it always holds
    // the current head entry; a write to that same entry is passed straight in.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            size_mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == head_next))
        begin
            head_rd_reg <= wr_data;
        end
        else
        begin
            head_rd_reg <= size_mem[head_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
            left_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        credits_reg <= credits_next;
        dropped_reg <= dropped_next;
        over_reg    <= over_next;
        if (cmd.capture)
        begin
            out_reg <= {HEAD_W'(head_shown), HELD_W'(occ_reg), over_reg, dropped_reg,
                        CREDITS_W'(credits_reg)};
        end
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

// ===== rtl/core/byte_to_packet_credit_return.sv =====
// Top level of the byte-to-packet credit return block.
// An accepted item passes through ST_WALK and ST_DONE before m_tvalid rises; a consumption
// takes N walk steps in ST_WALK, N at most QUEUE_DEPTH + 1, and an arrival takes none,
// one FIFO entry per cycle through the single head read port of the size FIFO.
// One item at a time: a new item is not accepted until the result is captured,
// and a result that waits holds the next item back.
// Reset clears pointers, occupancy and handshake state; FIFO contents stay unknown.
`default_nettype none
module byte_to_packet_credit_return (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] amount
    input  wire logic        s_tuser,   // [0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [4:0] credits_returned, [5] entry_dropped,
                                        // [6] overconsumed, [11:7] packets_held,
                                        // [23:12] head_remaining
);
    import b2pcr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    b2pcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    b2pcr_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .func     (s_tuser),
        .amount   (s_tdata[AMOUNT_W-1:0]),
        .out_data (m_tdata)
    );

endmodule
`default_nettype wire

// ===== rtl/core/b2pcr_chk.sv =====
// Port-level checker for the packet credit return block, bound to the top level.
`default_nettype none
module b2pcr_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);
    import b2pcr_pkg::*;

    // A held result must not vanish before it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before it was taken");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in work");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[5] && m_tdata[6]))
        else $error("drop and overconsumption flagged together");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5] |-> m_tdata[11:7] == HELD_W'(QUEUE_DEPTH))
        else $error("entry dropped while the FIFO was not full");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[11:7] == '0 |-> m_tdata[23:12] == '0)
        else $error("empty FIFO reports head bytes");

endmodule

bind byte_to_packet_credit_return b2pcr_chk u_b2pcr_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the byte-to-packet credit return block.
module tb_top;
    import b2pcr_pkg::*;

    localparam int TOTAL_ITEMS = 750;
    localparam int STALL_LIMIT = 2000;
    localparam int CALM_FIRST  = 350;
    localparam int CALM_LAST   = 500;
    localparam int IDLE_PCT    = 32;

    typedef struct packed {
        logic                func;
        logic [AMOUNT_W-1:0] amount;
    } credit_event_t;

    typedef struct packed {
        logic [CREDITS_W-1:0] credits;
        logic                 dropped;
        logic                 over;
        logic [HELD_W-1:0]    held;
        logic [HEAD_W-1:0]    head;
    } credit_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    credit_event_t  event_q[$];
    credit_report_t report_q[$];
    int             items_sent = 0;
    int             reports_seen = 0;
    int             mismatches = 0;

    // Shadow of the size FIFO and its pointers.
    logic [HEAD_W-1:0] pkt_bytes [QUEUE_DEPTH];
    logic [PTR_W-1:0]  rd_ptr = '0;
    logic [PTR_W-1:0]  wr_ptr = '0;
    logic [HELD_W-1:0] held_cnt = '0;

    byte_to_packet_credit_return DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Applies one arrival or consumption to the shadow FIFO and returns the report.
    function automatic credit_report_t account_credit(input logic func,
                                                      input logic [AMOUNT_W-1:0] amount);
        credit_report_t rpt;
        int unsigned    left;
        logic           walking;
        rpt = '0;
        if (func == FUNC_ARRIVAL)
        begin
            if (amount == 0)
                rpt.credits = CREDITS_W'(1);
            else if (held_cnt >= QUEUE_DEPTH)
                rpt.dropped = 1'b1;
            else
            begin
                pkt_bytes[wr_ptr] = HEAD_W'((amount > MAX_PACKET_BYTES) ?
                                            MAX_PACKET_BYTES : int'(amount));
                wr_ptr = wrap_next(wr_ptr);
                held_cnt = held_cnt + 1'b1;
            end
        end
        else
        begin
            left = 32'(amount);
            walking = (left > 0);
            while (walking)
            begin
                if (held_cnt == 0)
                begin
                    rpt.over = 1'b1;
                    walking = 1'b0;
                end
                else if (left >= pkt_bytes[rd_ptr])
                begin
                    left = left - pkt_bytes[rd_ptr];
                    rd_ptr = wrap_next(rd_ptr);
                    held_cnt = held_cnt - 1'b1;
                    rpt.credits = rpt.credits + 1'b1;
                    walking = (left > 0);
                end
                else
                begin
                    pkt_bytes[rd_ptr] = HEAD_W'(pkt_bytes[rd_ptr] - left);
                    walking = 1'b0;
                end
            end
        end
        rpt.held = held_cnt;
        rpt.head = (held_cnt == 0) ? '0 : pkt_bytes[rd_ptr];
        return rpt;
    endfunction

    task automatic add_event(input logic func, input int unsigned amount);
        credit_event_t ev;
        ev.func = func;
        ev.amount = amount[AMOUNT_W-1:0];
        event_q.push_back(ev);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Driver: presents queued items and records the expected report on acceptance.
    always @(posedge clk)
    begin : drive_events
        credit_event_t nxt;
        if (s_tvalid && s_tready)
            report_q.push_back(account_credit(s_tuser, s_tdata));
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !s_tready)
            ;
        else if (event_q.size() > 0 &&
                 ((items_sent >= CALM_FIRST && items_sent < CALM_LAST) ||
                  $urandom_range(0, 99) >= IDLE_PCT))
        begin
            nxt = event_q.pop_front();
            s_tvalid <= 1'b1;
            s_tdata <= nxt.amount;
            s_tuser <= nxt.func;
            items_sent++;
        end
        else
            s_tvalid <= 1'b0;
    end

    // Monitor: compares each returned report with the oldest expectation.
    always @(posedge clk)
    begin : watch_reports
        credit_report_t want;
        credit_report_t got;
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= (reports_seen >= CALM_FIRST && reports_seen < CALM_LAST) ||
                        ($urandom_range(0, 99) >= IDLE_PCT);
        if (rst_n && m_tvalid && m_tready)
        begin
            got.credits = m_tdata[4:0];
            got.dropped = m_tdata[5];
            got.over = m_tdata[6];
            got.held = m_tdata[11:7];
            got.head = m_tdata[23:12];
            if (report_q.size() == 0)
            begin
                $error("report with no pending event: tdata expected none, actual %h",
                       m_tdata);
                mismatches++;
            end
            else
            begin
                want = report_q.pop_front();
                check_field("credits_returned", 16'(want.credits), 16'(got.credits));
                check_field("entry_dropped", 16'(want.dropped), 16'(got.dropped));
                check_field("overconsumed", 16'(want.over), 16'(got.over));
                check_field("packets_held", 16'(want.held), 16'(got.held));
                check_field("head_remaining", 16'(want.head), 16'(got.head));
            end
            reports_seen++;
        end
    end

    initial
    begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stalled = 0;
            else
                stalled++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int mode;
        int burst;
        int pick;
        int arrive_pct;

        // Empty FIFO: nothing consumed, then bytes with nothing queued.
        add_event(FUNC_CONSUME, 0);
        add_event(FUNC_CONSUME, 5);
        // Zero-length arrival, smallest and largest lengths, a saturated one.
        add_event(FUNC_ARRIVAL, 0);
        add_event(FUNC_ARRIVAL, 1);
        add_event(FUNC_ARRIVAL, MAX_PACKET_BYTES);
        add_event(FUNC_ARRIVAL, 65535);
        add_event(FUNC_CONSUME, 1);
        // Fill the FIFO, then hit it with a dropped arrival and a zero-length one.
        for (int k = 0; k < QUEUE_DEPTH - 2; k++)
            add_event(FUNC_ARRIVAL, k * 37 + 1);
        add_event(FUNC_ARRIVAL, 300);
        add_event(FUNC_ARRIVAL, 0);
        add_event(FUNC_CONSUME, 100);
        // Drains every entry and runs past the end.
        add_event(FUNC_CONSUME, 65535);
        add_event(FUNC_CONSUME, 0);

        // Random bursts that lean toward filling, draining, or neither.
        while (event_q.size() < TOTAL_ITEMS)
        begin
            mode = $urandom_range(0, 2);
            burst = $urandom_range(6, 24);
            arrive_pct = (mode == 0) ? 85 : (mode == 1) ? 25 : 55;
            repeat (burst)
            begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < arrive_pct)
                begin
                    if (pick < 5)
                        add_event(FUNC_ARRIVAL, 0);
                    else if (pick < 15)
                        add_event(FUNC_ARRIVAL, $urandom_range(1, 16));
                    else if (pick < 90)
                        add_event(FUNC_ARRIVAL, $urandom_range(1, MAX_PACKET_BYTES));
                    else
                        add_event(FUNC_ARRIVAL, $urandom_range(MAX_PACKET_BYTES + 1, 65535));
                end
                else if (mode == 0 || pick < 35)
                    add_event(FUNC_CONSUME, (pick < 4) ? 0 : $urandom_range(1, 64));
                else if (pick < 75)
                    add_event(FUNC_CONSUME, $urandom_range(1, MAX_PACKET_BYTES));
                else if (pick < 95)
                    add_event(FUNC_CONSUME,
                              $urandom_range(MAX_PACKET_BYTES, 6 * MAX_PACKET_BYTES));
                else
                    add_event(FUNC_CONSUME, $urandom_range(0, 65535));
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (event_q.size() > 0 || s_tvalid || report_q.size() > 0)
            @(posedge clk);
        // Wait on past the last report, so that a stray extra report would show up.
        repeat (QUEUE_DEPTH + 8) @(posedge clk);

        if (mismatches == 0 && report_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
